/* design/fpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared widths, operation codes and pipeline word types of the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 8;
  localparam int CMD_WIDTH  = 4;
  localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_MIN,
    CMD_MAX,
    CMD_INC,
    CMD_DEC,
    CMD_ITOF,
    CMD_FTOI
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [DATA_WIDTH-1:0] res;
    logic                  less;
    logic                  equal;
    logic                  greater;
    logic                  dz;
  } side_t;

  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] r;
    logic [DIV_STEPS-1:0]  dq;
    logic [DATA_WIDTH-1:0] mb;
    logic                  neg;
    side_t                 side;
  } div_t;

endpackage

/* design/fpa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Input register, then one stage of compare, add/shift operations, the
// 32x32 product and divider setup (operand magnitudes and quotient sign).
// ----------------------------------------------------------------------------
module fpa_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [fpa_pkg::CMD_WIDTH-1:0]         cmd,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_a,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_b,
  output fpa_pkg::div_t                         stage_out
);
  import fpa_pkg::*;

  logic                           a_valid;
  logic [CMD_WIDTH-1:0]           a_cmd;
  logic signed [DATA_WIDTH-1:0]   a_op;
  logic signed [DATA_WIDTH-1:0]   b_op;
  logic                           less;
  logic                           greater;
  logic signed [2*DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0]          mag_a;
  logic [DATA_WIDTH-1:0]          mag_b;
  side_t                          side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_cmd <= cmd;
      a_op  <= operand_a;
      b_op  <= operand_b;
    end
  end

  assign less    = a_op < b_op;
  assign greater = b_op < a_op;
  assign prod    = a_op * b_op;
  assign mag_a   = a_op[DATA_WIDTH-1] ? DATA_WIDTH'(-a_op) : DATA_WIDTH'(a_op);
  assign mag_b   = b_op[DATA_WIDTH-1] ? DATA_WIDTH'(-b_op) : DATA_WIDTH'(b_op);

  always_comb begin
    side_next.cmd     = cmd_t'(a_cmd);
    side_next.less    = less;
    side_next.equal   = (a_op == b_op);
    side_next.greater = greater;
    side_next.dz      = 1'b0;
    side_next.res     = '0;
    unique case (cmd_t'(a_cmd))
      CMD_ADD:  side_next.res = a_op + b_op;
      CMD_SUB:  side_next.res = a_op - b_op;
      CMD_MUL:  side_next.res = prod[FRAC_BITS +: DATA_WIDTH];
      CMD_DIV:  side_next.dz  = (b_op == '0);
      CMD_MIN:  side_next.res = less ? a_op : b_op;
      CMD_MAX:  side_next.res = greater ? a_op : b_op;
      CMD_INC:  side_next.res = a_op + 1'b1;
      CMD_DEC:  side_next.res = a_op - 1'b1;
      CMD_ITOF: side_next.res = a_op <<< FRAC_BITS;
      CMD_FTOI: side_next.res = a_op >>> FRAC_BITS;
      default:  side_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_out.r    <= '0;
      stage_out.dq   <= {mag_a, FRAC_BITS'(0)};
      stage_out.mb   <= mag_b;
      stage_out.neg  <= a_op[DATA_WIDTH-1] ^ b_op[DATA_WIDTH-1];
      stage_out.side <= side_next;
    end
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= a_valid;
    end
  end

endmodule

/* design/fpa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage. The dividend
// shifts out of dq at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module fpa_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  fpa_pkg::div_t stage_in,
  output fpa_pkg::div_t stage_out
);
  import fpa_pkg::*;

  div_t stg [DIV_STEPS+1];

  function automatic div_t div_step(input div_t s);
    div_t              o;
    logic [DATA_WIDTH:0] rs;
    logic              ge;
    o    = s;
    rs   = {s.r, s.dq[DIV_STEPS-1]};
    ge   = rs >= {1'b0, s.mb};
    o.r  = ge ? DATA_WIDTH'(rs - {1'b0, s.mb}) : rs[DATA_WIDTH-1:0];
    o.dq = {s.dq[DIV_STEPS-2:0], ge};
    return o;
  endfunction

  assign stg[0] = stage_in;

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].valid <= 1'b0;
      end else if (en) begin
        stg[k] <= div_step(stg[k-1]);
      end
    end
  end

  assign stage_out = stg[DIV_STEPS];

endmodule

/* design/fpa_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_out
// Output register: fix the quotient sign, pick the final result and hold
// the word until the consumer takes it.
// ----------------------------------------------------------------------------
module fpa_out (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  fpa_pkg::div_t                         stage_in,
  output logic                                  out_valid,
  output logic signed [fpa_pkg::DATA_WIDTH-1:0] result,
  output logic                                  a_less,
  output logic                                  a_equal,
  output logic                                  a_greater,
  output logic                                  divide_by_zero
);
  import fpa_pkg::*;

  logic [DATA_WIDTH-1:0] quot;
  logic [DATA_WIDTH-1:0] res_next;

  assign quot = stage_in.dq[DATA_WIDTH-1:0];

  always_comb begin
    res_next = stage_in.side.res;
    if (stage_in.side.cmd == CMD_DIV && !stage_in.side.dz) begin
      res_next = stage_in.neg ? -quot : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= stage_in.valid;
    end
    if (load) begin
      result         <= res_next;
      a_less         <= stage_in.side.less;
      a_equal        <= stage_in.side.equal;
      a_greater      <= stage_in.side.greater;
      divide_by_zero <= stage_in.side.dz;
    end
  end

endmodule

/* design/fixed_point_q24_8_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 ALU: add, sub, mul, div, min, max, inc, dec and conversions,
// with A/B compare flags on every result.
// Path for every command: input and front registers, divider, output register.
// Throughput: one word per cycle while not stalled; 40-stage divider pipeline.
// Pipeline advances while its last stage is empty, even with output held.
// Reset: synchronous, clears all valid bits; no words in flight afterwards.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [fpa_pkg::CMD_WIDTH-1:0]         cmd,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_a,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_b,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fpa_pkg::DATA_WIDTH-1:0] result,
  output logic                                  a_less,
  output logic                                  a_equal,
  output logic                                  a_greater,
  output logic                                  divide_by_zero
);
  import fpa_pkg::*;

  div_t front;
  div_t last;
  logic en;
  logic load;

  assign load     = !out_valid || out_ready;
  assign en       = load || !last.valid;
  assign in_ready = en;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .stage_out (front)
  );

  fpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .stage_in  (front),
    .stage_out (last)
  );

  fpa_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .stage_in       (last),
    .out_valid      (out_valid),
    .result         (result),
    .a_less         (a_less),
    .a_equal        (a_equal),
    .a_greater      (a_greater),
    .divide_by_zero (divide_by_zero)
  );

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result == '0)
    else $error("divide by zero word carries nonzero result");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not one-hot");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && last.valid |=> last.valid && $stable(last.side))
    else $error("pipeline word lost during output stall");
`endif

endmodule
